>>> rtl/wrs_pkg.sv
// Shared types and constants for the WAV stream parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package wrs_pkg;

  localparam int MAX_FRAME_BYTES = 8;
  localparam int FBI_W = $clog2(MAX_FRAME_BYTES);
  localparam int FB_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM = 16'd1;

  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_BAD_TAG = 3'd2;
  localparam logic [2:0] KIND_NOT_PCM = 3'd3;
  localparam logic [2:0] KIND_LAYOUT = 3'd4;

  localparam logic [1:0] REG_START_FRAME = 2'd0;
  localparam logic [1:0] REG_FRAME_LIMIT = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [15:0] sample;
    logic last;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_depth;
    logic [31:0] data_bytes;
    logic [31:0] payload_start;
    logic [31:0] frame_total;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/wav_riff_stream_parser.sv
// Top level of the WAV stream parser: config registers, parser, divider, queue.
// Depends on wrs_pkg, wrs_front, wrs_div and wrs_fifo.
//
// Takes one file byte per cycle while not stalled, checks the RIFF/WAVE tags,
// walks the sub-chunks, latches the PCM fmt fields and emits one header result
// at the data chunk, then one sample per frame, built from the first two bytes
// of the frame, inside the window set by start_frame and frame_limit. After the
// last byte of the data chunk header the frame total is found by a bit-serial
// divider, and the byte input stalls until it is done and the header result is
// queued; a malformed file gives an error result. A two-entry queue holds results,
// so output back-pressure stalls the byte input only once that queue is full.
`default_nettype none
module wav_riff_stream_parser import wrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        file_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic signed [15:0] sample,
  output logic             last,
  output logic [15:0]      channels,
  output logic [31:0]      rate_hz,
  output logic [15:0]      sample_depth,
  output logic [31:0]      data_bytes,
  output logic [31:0]      payload_start,
  output logic [31:0]      frame_total,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] start_frame, frame_limit;
  logic q_room, q_push, q_pop;
  res_t q_data, q_head;
  logic [QCNT_W-1:0] q_count;
  logic div_start, div_busy;
  logic [31:0] div_dividend, div_quot;
  logic [FB_W-1:0] div_divisor;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame <= '0;
      frame_limit <= '1;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_FRAME) begin
        start_frame <= cfg_data;
      end else if (cfg_index == REG_FRAME_LIMIT) begin
        frame_limit <= cfg_data;
      end
    end
  end

  wrs_front u_front (
    .clk, .rst, .in_valid, .in_ready, .byte_in, .file_start,
    .start_frame, .frame_limit, .q_room, .q_push, .q_data,
    .div_start, .div_dividend, .div_divisor, .div_busy, .div_quot
  );

  wrs_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quot(div_quot)
  );

  assign q_pop = out_valid && out_ready;

  wrs_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_data(q_data), .pop(q_pop),
    .room(q_room), .not_empty(out_valid), .head(q_head), .count(q_count)
  );

  assign kind = q_head.kind;
  assign sample = q_head.sample;
  assign last = q_head.last;
  assign channels = q_head.channels;
  assign rate_hz = q_head.rate_hz;
  assign sample_depth = q_head.sample_depth;
  assign data_bytes = q_head.data_bytes;
  assign payload_start = q_head.payload_start;
  assign frame_total = q_head.frame_total;

  // no byte is taken while the frame total is being divided out
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !in_ready) else $error("byte accepted during division");

  // the queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH)) else $error("result queue overflow");

  // non-sample results carry a zero sample field
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_SAMPLE) |-> (sample == 16'sd0 && !last))
    else $error("stray sample field");

endmodule
`default_nettype wire

>>> rtl/wrs_div.sv
// Iterative restoring divider: 32-bit dividend by a small frame size.
// Depends on wrs_pkg for the divisor width.
`default_nettype none
module wrs_div import wrs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [31:0]     dividend,
  input  wire logic [FB_W-1:0] divisor,
  output logic                 busy,
  output logic [31:0]          quot
);

  logic [FB_W-1:0] rem;
  logic [FB_W-1:0] dvs;
  logic [5:0] cnt;
  logic [FB_W:0] trial;

  // one quotient bit per cycle
  assign trial = {rem, quot[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      rem <= '0;
      dvs <= divisor;
      quot <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= FB_W'(trial - {1'b0, dvs});
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem <= trial[FB_W-1:0];
        quot <= {quot[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/wrs_fifo.sv
// Short result queue between the parser front and the output port.
// Depends on wrs_pkg for the result type and depth.
`default_nettype none
module wrs_fifo import wrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire res_t  push_data,
  input  wire logic  pop,
  output logic       room,
  output logic       not_empty,
  output res_t       head,
  output logic [QCNT_W-1:0] count
);

  res_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign room = count != QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head = mem[rd_ptr];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wrs_front.sv
// Byte-level RIFF/WAVE parser: tags, chunk walk, fmt latches, frame window.
// Depends on wrs_pkg; drives wrs_div and pushes results into wrs_fifo.
`default_nettype none
module wrs_front import wrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        file_start,
  input  wire logic [31:0] start_frame,
  input  wire logic [31:0] frame_limit,
  input  wire logic        q_room,
  output logic             q_push,
  output res_t             q_data,
  output logic             div_start,
  output logic [31:0]      div_dividend,
  output logic [FB_W-1:0]  div_divisor,
  input  wire logic        div_busy,
  input  wire logic [31:0] div_quot
);

  typedef enum logic [2:0] {
    PH_TOP, PH_HDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_IDLE, PH_DIVW
  } phase_t;

  phase_t phase, phase_next;
  logic [3:0] k, k_next;
  logic [31:0] tag, tag_next, len, len_next, skip, skip_next, pos, pos_next;
  logic [15:0] ch, ch_next, dep, dep_next;
  logic [31:0] rate, rate_next, frames, frames_next, fidx, fidx_next;
  logic fseen, fseen_next;
  logic [FBI_W-1:0] fbi, fbi_next;
  logic [FB_W-1:0] fb, fb_next;
  logic [7:0] low, low_next;

  logic accept;
  logic [31:0] off, prod;
  logic [32:0] win_end, win_endc;
  res_t res;
  logic res_v;

  assign accept = in_valid && in_ready;
  assign in_ready = (phase != PH_DIVW) && q_room;
  assign prod = {3'b0, dep[15:3]} * ch;
  assign div_dividend = len_next;
  assign div_divisor = fb_next;

  // next-state logic for one accepted byte, or the wait on the divider
  always_comb begin
    res = '0;
    res_v = 1'b0;
    div_start = 1'b0;
    phase_next = phase;
    k_next = k; tag_next = tag; len_next = len; skip_next = skip; pos_next = pos;
    ch_next = ch; dep_next = dep; rate_next = rate; frames_next = frames;
    fidx_next = fidx; fseen_next = fseen; fbi_next = fbi; fb_next = fb;
    low_next = low;
    off = '0;
    win_end = '0;
    win_endc = '0;
    if (phase == PH_DIVW) begin
      // hand out the header once the frame count is known
      if (!div_busy && q_room) begin
        res_v = 1'b1;
        res.kind = KIND_HEADER;
        res.channels = ch;
        res.rate_hz = rate;
        res.sample_depth = dep;
        res.data_bytes = len;
        res.payload_start = pos;
        res.frame_total = div_quot;
        frames_next = div_quot;
        fidx_next = '0;
        fbi_next = '0;
        phase_next = (div_quot != '0) ? PH_DATA : PH_IDLE;
      end
    end else if (accept) begin
      if (file_start) begin
        phase_next = PH_TOP;
        k_next = '0; tag_next = '0; len_next = '0; skip_next = '0; pos_next = '0;
        ch_next = '0; dep_next = '0; rate_next = '0; frames_next = '0;
        fidx_next = '0; fseen_next = 1'b0; fbi_next = '0; low_next = '0;
      end
      pos_next = pos_next + 32'd1;
      unique case (phase_next)
        PH_TOP: begin
          if (k_next < 4'd4 || (k_next >= 4'd8 && k_next < 4'd12)) begin
            tag_next = tag_next | (32'(byte_in) << {k_next[1:0], 3'b000});
          end
          if (k_next == 4'd3) begin
            if (tag_next != TAG_RIFF) begin
              res_v = 1'b1; res.kind = KIND_BAD_TAG; phase_next = PH_IDLE;
            end else begin
              tag_next = '0;
              k_next = k_next + 4'd1;
            end
          end else if (k_next >= 4'd11) begin
            if (tag_next != TAG_WAVE) begin
              res_v = 1'b1; res.kind = KIND_BAD_TAG; phase_next = PH_IDLE;
            end else begin
              phase_next = PH_HDR;
              k_next = '0;
            end
          end else begin
            k_next = k_next + 4'd1;
          end
        end
        PH_HDR: begin
          if (k_next == 4'd0) begin
            tag_next = 32'(byte_in);
          end else if (k_next < 4'd4) begin
            tag_next = tag_next | (32'(byte_in) << {k_next[1:0], 3'b000});
          end else if (k_next == 4'd4) begin
            len_next = 32'(byte_in);
          end else begin
            len_next = len_next | (32'(byte_in) << {k_next[1:0], 3'b000});
          end
          if (k_next < 4'd7) begin
            k_next = k_next + 4'd1;
          end else begin
            k_next = '0;
            if (tag_next == TAG_FMT) begin
              ch_next = '0; rate_next = '0; dep_next = '0; tag_next = '0;
              skip_next = len_next;
              if (len_next == '0) begin
                // empty fmt body carries no format code
                res_v = 1'b1; res.kind = KIND_NOT_PCM; phase_next = PH_IDLE;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (tag_next == TAG_DATA) begin
              if (!fseen_next || ch_next == '0 || prod < 32'd2 ||
                  prod > 32'(MAX_FRAME_BYTES)) begin
                res_v = 1'b1; res.kind = KIND_LAYOUT; phase_next = PH_IDLE;
              end else begin
                fb_next = prod[FB_W-1:0];
                div_start = 1'b1;
                phase_next = PH_DIVW;
              end
            end else begin
              skip_next = len_next;
              phase_next = (len_next != '0) ? PH_SKIP : PH_HDR;
            end
          end
        end
        PH_FMT: begin
          off = len_next - skip_next;
          if (off < 32'd2) begin
            tag_next = tag_next | (32'(byte_in) << {off[1:0], 3'b000});
          end else if (off < 32'd4) begin
            ch_next = ch_next | (16'(byte_in) << {off[0], 3'b000});
          end else if (off < 32'd8) begin
            rate_next = rate_next | (32'(byte_in) << {off[1:0], 3'b000});
          end else if (off == 32'd14 || off == 32'd15) begin
            dep_next = dep_next | (16'(byte_in) << {off[0], 3'b000});
          end
          skip_next = skip_next - 32'd1;
          if (skip_next == '0) begin
            if (tag_next[15:0] != FMT_PCM) begin
              res_v = 1'b1; res.kind = KIND_NOT_PCM; phase_next = PH_IDLE;
            end else begin
              fseen_next = 1'b1;
              phase_next = PH_HDR;
              k_next = '0;
            end
          end
        end
        PH_SKIP: begin
          skip_next = skip_next - 32'd1;
          if (skip_next == '0) begin
            phase_next = len_next[0] ? PH_PAD : PH_HDR;
            k_next = '0;
          end
        end
        PH_PAD: begin
          phase_next = PH_HDR;
          k_next = '0;
        end
        PH_DATA: begin
          if (fbi_next == '0) begin
            low_next = byte_in;
          end else if (fbi_next == FBI_W'(1)) begin
            tag_next = {16'h0, byte_in, low_next};
          end
          if (FB_W'(fbi_next) + FB_W'(1) < fb_next) begin
            fbi_next = fbi_next + 1'b1;
          end else begin
            // frame complete: emit if inside the window
            fbi_next = '0;
            win_end = {1'b0, start_frame} + {1'b0, frame_limit};
            win_endc = (win_end > {1'b0, frames_next}) ? {1'b0, frames_next} : win_end;
            if (fidx_next >= start_frame && {1'b0, fidx_next} < win_endc) begin
              res_v = 1'b1;
              res.kind = KIND_SAMPLE;
              res.sample = tag_next[15:0];
              res.last = ({1'b0, fidx_next} + 33'd1) == win_endc;
            end
            fidx_next = fidx_next + 32'd1;
            if (fidx_next >= frames_next) begin
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push = res_v;
  assign q_data = res;

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOP;
      k <= '0; tag <= '0; len <= '0; skip <= '0; pos <= '0;
      ch <= '0; dep <= '0; rate <= '0; frames <= '0; fidx <= '0;
      fseen <= 1'b0; fbi <= '0; fb <= '0; low <= '0;
    end else begin
      phase <= phase_next;
      k <= k_next; tag <= tag_next; len <= len_next; skip <= skip_next;
      pos <= pos_next; ch <= ch_next; dep <= dep_next; rate <= rate_next;
      frames <= frames_next; fidx <= fidx_next; fseen <= fseen_next;
      fbi <= fbi_next; fb <= fb_next; low <= low_next;
    end
  end

endmodule
`default_nettype wire

>>> sim/wrs_checker.sv
// Checker for the WAV stream parser: watches the byte and result channels,
// predicts the results of each accepted byte and compares them field by field.
// Depends on wrs_pkg for result kinds and tag constants.
`timescale 1ns / 1ps
module wrs_checker import wrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        file_start,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  kind,
  input  wire logic signed [15:0] sample,
  input  wire logic        last,
  input  wire logic [15:0] channels,
  input  wire logic [31:0] rate_hz,
  input  wire logic [15:0] sample_depth,
  input  wire logic [31:0] data_bytes,
  input  wire logic [31:0] payload_start,
  input  wire logic [31:0] frame_total,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef enum logic [2:0] {
    P_TOP, P_HDR, P_FMT, P_SKIP, P_PAD, P_DATA, P_IDLE
  } phase_e;

  res_t expected_q[$];

  logic [31:0] win_start, win_limit;
  phase_e      phase;
  logic [31:0] nbyte, tag, clen, skip_left, pos, rate, nframes, fidx;
  logic [15:0] chans, depth;
  logic        have_fmt;
  logic [3:0]  fbyte;
  logic [7:0]  low_byte;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [31:0] frame_len();
    return 32'(depth >> 3) * 32'(chans);
  endfunction

  task automatic clear_file();
    phase = P_TOP; nbyte = 0; tag = 0; clen = 0; skip_left = 0; pos = 0;
    chans = 0; rate = 0; depth = 0; have_fmt = 0; nframes = 0; fidx = 0;
    fbyte = 0; low_byte = 0;
  endtask

  task automatic push_error(input logic [2:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    expected_q.push_back(r);
    phase = P_IDLE;
  endtask

  task automatic close_fmt();
    if (tag[15:0] != FMT_PCM) begin
      push_error(KIND_NOT_PCM);
    end else begin
      have_fmt = 1; phase = P_HDR; nbyte = 0;
    end
  endtask

  task automatic open_data();
    res_t r;
    logic [31:0] fb;
    fb = frame_len();
    if (!have_fmt || chans == 0 || fb < 2 || fb > MAX_FRAME_BYTES) begin
      push_error(KIND_LAYOUT);
      return;
    end
    nframes = clen / fb;
    r = '0;
    r.kind = KIND_HEADER; r.channels = chans; r.rate_hz = rate;
    r.sample_depth = depth; r.data_bytes = clen; r.payload_start = pos;
    r.frame_total = nframes;
    expected_q.push_back(r);
    fidx = 0; fbyte = 0;
    phase = (nframes != 0) ? P_DATA : P_IDLE;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic restart);
    logic [31:0] off;
    logic [32:0] stop;
    res_t r;
    if (restart) clear_file();
    pos++;
    case (phase)
      P_TOP: begin
        if (nbyte < 4) tag |= 32'(b) << (8 * nbyte);
        else if (nbyte >= 8) tag |= 32'(b) << (8 * (nbyte - 8));
        if (nbyte == 3) begin
          if (tag != TAG_RIFF) push_error(KIND_BAD_TAG);
          else begin tag = 0; nbyte++; end
        end else if (nbyte >= 11) begin
          if (tag != TAG_WAVE) push_error(KIND_BAD_TAG);
          else begin phase = P_HDR; nbyte = 0; end
        end else nbyte++;
      end
      P_HDR: begin
        if (nbyte == 0) tag = 32'(b);
        else if (nbyte < 4) tag |= 32'(b) << (8 * nbyte);
        else if (nbyte == 4) clen = 32'(b);
        else clen |= 32'(b) << (8 * (nbyte - 4));
        if (nbyte < 7) nbyte++;
        else begin
          nbyte = 0;
          if (tag == TAG_FMT) begin
            chans = 0; rate = 0; depth = 0; tag = 0; skip_left = clen;
            if (clen == 0) close_fmt();
            else phase = P_FMT;
          end else if (tag == TAG_DATA) begin
            open_data();
          end else begin
            skip_left = clen;
            phase = (clen != 0) ? P_SKIP : P_HDR;
          end
        end
      end
      P_FMT: begin
        off = clen - skip_left;
        if (off < 2) tag |= 32'(b) << (8 * off);
        else if (off < 4) chans |= 16'(16'(b) << (8 * (off - 2)));
        else if (off < 8) rate |= 32'(b) << (8 * (off - 4));
        else if (off == 14 || off == 15) depth |= 16'(16'(b) << (8 * (off - 14)));
        skip_left--;
        if (skip_left == 0) close_fmt();
      end
      P_SKIP: begin
        skip_left--;
        if (skip_left == 0) begin
          phase = clen[0] ? P_PAD : P_HDR;
          nbyte = 0;
        end
      end
      P_PAD: begin
        phase = P_HDR; nbyte = 0;
      end
      P_DATA: begin
        if (fbyte == 0) low_byte = b;
        else if (fbyte == 1) tag = {16'h0, b, low_byte};
        if (32'(fbyte) + 1 < frame_len()) fbyte++;
        else begin
          fbyte = 0;
          stop = 33'(win_start) + 33'(win_limit);
          if (stop > 33'(nframes)) stop = 33'(nframes);
          if (fidx >= win_start && 33'(fidx) < stop) begin
            r = '0;
            r.kind = KIND_SAMPLE;
            r.sample = tag[15:0];
            r.last = (33'(fidx) + 1 == stop);
            expected_q.push_back(r);
          end
          fidx++;
          if (fidx >= nframes) phase = P_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      win_start <= 0;
      win_limit <= 32'hFFFF_FFFF;
      clear_file();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we && cfg_index == REG_START_FRAME) win_start = cfg_data;
      if (cfg_we && cfg_index == REG_FRAME_LIMIT) win_limit = cfg_data;
      if (in_valid && in_ready) take_byte(byte_in, file_start);
      if (out_valid && out_ready) begin
        got = '{kind, sample, last, channels, rate_hz, sample_depth,
                data_bytes, payload_start, frame_total};
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind)
            report($sformatf("kind %0d want %0d", got.kind, want.kind));
          if (got.sample != want.sample)
            report($sformatf("sample %0d want %0d", got.sample, want.sample));
          if (got.last != want.last)
            report($sformatf("last %0d want %0d", got.last, want.last));
          if (got.channels != want.channels)
            report($sformatf("channels %0d want %0d", got.channels, want.channels));
          if (got.rate_hz != want.rate_hz)
            report($sformatf("rate %0d want %0d", got.rate_hz, want.rate_hz));
          if (got.sample_depth != want.sample_depth)
            report($sformatf("depth %0d want %0d", got.sample_depth,
                             want.sample_depth));
          if (got.data_bytes != want.data_bytes)
            report($sformatf("data_bytes %0d want %0d", got.data_bytes, want.data_bytes));
          if (got.payload_start != want.payload_start)
            report($sformatf("offset %0d want %0d", got.payload_start,
                             want.payload_start));
          if (got.frame_total != want.frame_total)
            report($sformatf("frames %0d want %0d", got.frame_total, want.frame_total));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> sim/tb_wav_riff_stream_parser.sv
// Testbench top for the WAV stream parser: clock, reset, file stimulus,
// register writes and verdict. Depends on wrs_pkg, wrs_checker and the RTL.
`timescale 1ns / 1ps
module tb_wav_riff_stream_parser;
  import wrs_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [7:0]  byte_in;
  logic        file_start;
  logic        out_valid, out_ready;
  logic [2:0]  kind;
  logic signed [15:0] sample;
  logic        last;
  logic [15:0] channels, sample_depth;
  logic [31:0] rate_hz, data_bytes, payload_start, frame_total;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, idle_cycles, sent;
  bit          calm;

  logic [7:0]  file_buf[$];

  wav_riff_stream_parser dut (.*);
  wrs_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Drain side: stall about 7 in 100 unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // Watchdog on accepted requests and results
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb_wav_riff_stream_parser: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; byte_in <= b; file_start <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Files follow back to back; the valid line drops in settle()
  task automatic send_file();
    foreach (file_buf[i]) send_byte(file_buf[i], i == 0);
    file_buf.delete();
  endtask

  task automatic put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_fmt(input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] rt, input logic [15:0] dp,
                         input logic [31:0] body);
    logic [7:0] f[16];
    f = '{default: 8'h00};
    {f[1], f[0]} = code; {f[3], f[2]} = ch;
    {f[7], f[6], f[5], f[4]} = rt; {f[15], f[14]} = dp;
    for (int i = 8; i < 14; i++) f[i] = 8'($urandom);
    put32(TAG_FMT); put32(body);
    for (int i = 0; i < body; i++) file_buf.push_back(i < 16 ? f[i] : 8'($urandom));
  endtask

  // Build a file; shape 0 well-formed, others break it in some way
  task automatic make_file(input int shape, input int ch, input int dp, input int frames);
    int fb, n;
    fb = (dp / 8) * ch;
    if (shape == 1) put32($urandom); else put32(TAG_RIFF);
    put32($urandom);
    if (shape == 2) put32($urandom); else put32(TAG_WAVE);
    // optional unknown chunk, odd or even
    if ($urandom_range(1)) begin
      n = $urandom_range(5);
      put32($urandom); put32(n);
      for (int i = 0; i < n + n % 2; i++) file_buf.push_back(8'($urandom));
    end
    if (shape != 3)
      put_fmt(shape == 4 ? 16'($urandom_range(2, 65535)) : FMT_PCM, 16'(ch), $urandom,
              16'(dp), shape == 5 ? $urandom_range(0, 15) : $urandom_range(16, 20));
    n = frames * fb + $urandom_range(fb > 0 ? fb - 1 : 0);
    put32(TAG_DATA); put32(n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
    for (int i = $urandom_range(3); i > 0; i--) file_buf.push_back(8'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int ch, dp, base;
    rst = 1; in_valid = 0; byte_in = 0; file_start = 0; out_ready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0; calm = 0; sent = 0; idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: plain files, extremes of layout and every error kind
    make_file(0, 1, 16, 3); send_file();
    make_file(0, 2, 32, 2); send_file();
    make_file(0, 1, 16, 0); send_file();
    make_file(0, 8, 8, 2); send_file();
    make_file(0, 1, 8, 2); send_file();
    make_file(0, 0, 16, 2); send_file();
    make_file(0, 3, 24, 2); send_file();
    make_file(1, 1, 16, 1); send_file();
    make_file(2, 1, 16, 1); send_file();
    make_file(3, 1, 16, 1); send_file();
    make_file(4, 1, 16, 1); send_file();
    make_file(5, 1, 16, 1); send_file();
    // Hold off until every expected result has drained
    settle();

    // Random: walk register settings, extremes included
    for (int phase_n = 0; phase_n < 8; phase_n++) begin
      case (phase_n)
        0: begin write_reg(REG_START_FRAME, 0); write_reg(REG_FRAME_LIMIT, 0); end
        1: begin write_reg(REG_START_FRAME, 32'hFFFF_FFFF);
                 write_reg(REG_FRAME_LIMIT, 32'hFFFF_FFFF); end
        2: begin write_reg(REG_START_FRAME, 2); write_reg(REG_FRAME_LIMIT, 3); end
        3: write_reg(2'd3, $urandom);
        default: begin write_reg(REG_START_FRAME, $urandom_range(4));
                       write_reg(REG_FRAME_LIMIT, $urandom_range(1, 6)); end
      endcase
      calm = (phase_n == 5);
      base = sent;
      while (sent < base + 160) begin
        ch = $urandom_range(1, 4);
        dp = 8 * $urandom_range(1, 2);
        if ($urandom_range(9) == 0) begin
          make_file($urandom_range(1, 5), ch, dp, $urandom_range(4));
        end else begin
          make_file(0, ch, dp, $urandom_range(12));
        end
        send_file();
      end
      calm = 0;
      settle();
    end

    settle();
    if (fail_count == 0) $display("tb_wav_riff_stream_parser: clean");
    else $display("tb_wav_riff_stream_parser: errors");
    $finish;
  end

endmodule
